// ===== hw/rtl/phfa_pkg.sv =====
// ----------------------------------------------------------------------------
// Page heap allocator package
// Sizes, derived widths and codes shared by the allocator files.
// ----------------------------------------------------------------------------
package phfa_pkg;

  localparam int HEAP_PAGES   = 1024;
  localparam int RECORD_SLOTS = 64;
  localparam int PAGE_BYTES   = 4096;

  localparam int WORD_BITS = 32;
  localparam int WORD_SH   = $clog2(WORD_BITS);
  localparam int WORDS     = (HEAP_PAGES + WORD_BITS - 1) / WORD_BITS;
  localparam int WA_W      = (WORDS > 1) ? $clog2(WORDS) : 1;
  localparam int PG_W      = $clog2(HEAP_PAGES);
  localparam int CNT_W     = $clog2(HEAP_PAGES + 1);
  localparam int SLOT_W    = (RECORD_SLOTS > 1) ? $clog2(RECORD_SLOTS) : 1;
  localparam int PB_SH     = $clog2(PAGE_BYTES);
  localparam int REC_W     = 1 + PG_W + CNT_W;
  localparam int CLR_N     = (WORDS > RECORD_SLOTS) ? WORDS : RECORD_SLOTS;
  localparam int CLR_W     = $clog2(CLR_N + 1);
  localparam int DIV_W     = 33;
  localparam int CFG_IDX_W = 2;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_FIT    = 3'd1;
  localparam logic [2:0] ST_ZERO      = 3'd2;
  localparam logic [2:0] ST_FULL      = 3'd3;
  localparam logic [2:0] ST_NOT_FOUND = 3'd4;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

  localparam logic [CFG_IDX_W-1:0] CFG_BEST_FIT  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAP_BASE = 2'd1;

endpackage

// ===== hw/rtl/phfa_ifs.sv =====
// ----------------------------------------------------------------------------
// Page heap allocator channels
// Request, response and register write channels with valid and ready.
// ----------------------------------------------------------------------------
interface phfa_req_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [31:0] req_size;
  logic [31:0] free_address;
  modport source (output valid, kind, req_size, free_address, input ready);
  modport sink (input valid, kind, req_size, free_address, output ready);
endinterface

interface phfa_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] result_address;
  logic [2:0]  status;
  modport source (output valid, result_address, status, input ready);
  modport sink (input valid, result_address, status, output ready);
endinterface

interface phfa_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [phfa_pkg::CFG_IDX_W-1:0]    index;
  logic [31:0]                       data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

// ===== hw/rtl/phfa_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module phfa_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== hw/rtl/page_heap_fit_allocator.sv =====
// ----------------------------------------------------------------------------
// Page heap allocator
// First-fit or best-fit page allocator over a used-page bitmap and a record
// table, run by one sequencer over two RAMs.
// ----------------------------------------------------------------------------
// After reset the block clears the bitmap and record RAMs before it takes a
// transaction. One request is handled at a time. An allocate first forms the
// page count, then scans the bitmap at one page per cycle, pausing to load
// each 32-page word and stopping early when first fit finds a run. It then
// searches the record slots for a free one, marks the bitmap words by reading
// and writing each in turn, and writes the record. A free checks the record
// slots, comparing the address of each valid one with the free address, then
// does the same marking. The bitmap scan is the dominant cost.
module page_heap_fit_allocator (
  input  logic           clk,
  input  logic           rst_n,
  phfa_req_if.sink       in_req,
  phfa_rsp_if.source     out_rsp,
  phfa_cfg_if.sink       cfg_wr
);

  typedef enum logic [13:0] {
    S_CLR   = 14'b00000000000001,
    S_IDLE  = 14'b00000000000010,
    S_DIV   = 14'b00000000000100,
    S_LOAD  = 14'b00000000001000,
    S_SCAN  = 14'b00000000010000,
    S_SRD   = 14'b00000000100000,
    S_SWT   = 14'b00000001000000,
    S_MSET  = 14'b00000010000000,
    S_MRD   = 14'b00000100000000,
    S_MWR   = 14'b00001000000000,
    S_RECWR = 14'b00010000000000,
    S_MUL   = 14'b00100000000000,
    S_FCMP  = 14'b01000000000000,
    S_DONE  = 14'b10000000000000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [phfa_pkg::CLR_W-1:0]      clr_r;
  logic                            best_fit_r;
  logic [31:0]                     heap_base_r;
  logic                            kind_r;
  logic [31:0]                     faddr_r;
  logic [phfa_pkg::DIV_W-1:0]      div_d_r;
  logic [phfa_pkg::CNT_W-1:0]      need_r;
  logic [phfa_pkg::CNT_W-1:0]      p_r;
  logic [phfa_pkg::WORD_SH-1:0]    b_r;
  logic [phfa_pkg::WA_W-1:0]       w_r;
  logic [phfa_pkg::CNT_W-1:0]      run_len_r, run_len_nxt;
  logic [phfa_pkg::PG_W-1:0]       run_start_r, run_start_nxt;
  logic                            found_r, found_nxt;
  logic [phfa_pkg::PG_W-1:0]       best_start_r, best_start_nxt;
  logic [phfa_pkg::CNT_W-1:0]      best_len_r, best_len_nxt;
  logic [phfa_pkg::SLOT_W-1:0]     s_r;
  logic [phfa_pkg::PG_W-1:0]       lo_r;
  logic [phfa_pkg::CNT_W-1:0]      cnt_r;
  logic [phfa_pkg::WA_W-1:0]       m_r, mlast_r;
  logic [31:0]                     prod_r;
  logic [2:0]                      status_r;
  logic                            out_valid_r;
  logic [31:0]                     out_addr_r;
  logic [2:0]                      out_status_r;

  logic                            free_here, stop, scan_end;
  logic [phfa_pkg::DIV_W-1:0]      need_q;
  logic [phfa_pkg::CNT_W-1:0]      hi;
  logic [31:0]                     mask;
  logic                            slot_last, match, out_load;

  logic                            bm_we;
  logic [phfa_pkg::WA_W-1:0]       bm_waddr, bm_raddr;
  logic [phfa_pkg::WORD_BITS-1:0]  bm_wdata, bm_rdata;
  logic                            rec_we;
  logic [phfa_pkg::SLOT_W-1:0]     rec_waddr;
  logic [phfa_pkg::REC_W-1:0]      rec_wdata, rec_rdata;
  logic                            rec_valid;
  logic [phfa_pkg::PG_W-1:0]       rec_start;
  logic [phfa_pkg::CNT_W-1:0]      rec_count;

  function automatic logic [phfa_pkg::WA_W-1:0] word_of(input logic [phfa_pkg::CNT_W-1:0] x);
    return phfa_pkg::WA_W'(32'(x) >> phfa_pkg::WORD_SH);
  endfunction

  phfa_ram #(.WIDTH(phfa_pkg::WORD_BITS), .DEPTH(phfa_pkg::WORDS)) u_bitmap (
    .clk(clk), .we(bm_we), .waddr(bm_waddr), .wdata(bm_wdata),
    .raddr(bm_raddr), .rdata(bm_rdata)
  );

  phfa_ram #(.WIDTH(phfa_pkg::REC_W), .DEPTH(phfa_pkg::RECORD_SLOTS)) u_records (
    .clk(clk), .we(rec_we), .waddr(rec_waddr), .wdata(rec_wdata),
    .raddr(s_r), .rdata(rec_rdata)
  );

  assign rec_valid = rec_rdata[phfa_pkg::REC_W-1];
  assign rec_start = rec_rdata[phfa_pkg::PG_W+phfa_pkg::CNT_W-1:phfa_pkg::CNT_W];
  assign rec_count = rec_rdata[phfa_pkg::CNT_W-1:0];

  assign in_req.ready   = (state_r == S_IDLE);
  assign cfg_wr.ready   = 1'b1;
  assign out_rsp.valid  = out_valid_r;
  assign out_rsp.result_address = out_addr_r;
  assign out_rsp.status = out_status_r;

  always_comb begin
    free_here = (p_r < phfa_pkg::CNT_W'(phfa_pkg::HEAP_PAGES)) && !bm_rdata[b_r];
    run_len_nxt    = run_len_r;
    run_start_nxt  = run_start_r;
    found_nxt      = found_r;
    best_start_nxt = best_start_r;
    best_len_nxt   = best_len_r;
    stop           = 1'b0;
    if (free_here) begin
      if (run_len_r == '0) begin
        run_start_nxt = phfa_pkg::PG_W'(p_r);
      end
      run_len_nxt = run_len_r + 1'b1;
    end else begin
      if (run_len_r != '0 && run_len_r >= need_r) begin
        if (!found_r || (best_fit_r && run_len_r < best_len_r)) begin
          found_nxt      = 1'b1;
          best_start_nxt = run_start_r;
          best_len_nxt   = run_len_r;
        end
        if (!best_fit_r) begin
          stop = 1'b1;
        end
      end
      run_len_nxt = '0;
    end
    scan_end = stop || (p_r == phfa_pkg::CNT_W'(phfa_pkg::HEAP_PAGES));
  end

  assign need_q = div_d_r >> phfa_pkg::PB_SH;

  assign hi = phfa_pkg::CNT_W'(lo_r) + cnt_r;

  always_comb begin
    for (int i = 0; i < phfa_pkg::WORD_BITS; i++) begin
      mask[i] = (((32'(m_r) << phfa_pkg::WORD_SH) + 32'(i)) >= 32'(lo_r)) &&
                (((32'(m_r) << phfa_pkg::WORD_SH) + 32'(i)) < 32'(hi));
    end
  end

  assign slot_last = (s_r == phfa_pkg::SLOT_W'(phfa_pkg::RECORD_SLOTS - 1));
  assign match     = ((heap_base_r + prod_r) == faddr_r);
  assign out_load  = (state_r == S_DONE) && (!out_valid_r || out_rsp.ready);

  always_comb begin
    bm_we     = 1'b0;
    bm_waddr  = m_r;
    bm_wdata  = (kind_r == phfa_pkg::KIND_ALLOC) ? (bm_rdata | mask) : (bm_rdata & ~mask);
    bm_raddr  = (state_r == S_LOAD || state_r == S_SCAN) ? w_r : m_r;
    rec_we    = 1'b0;
    rec_waddr = s_r;
    rec_wdata = (kind_r == phfa_pkg::KIND_ALLOC) ? {1'b1, lo_r, cnt_r} : '0;
    if (state_r == S_CLR) begin
      bm_we     = (clr_r < phfa_pkg::CLR_W'(phfa_pkg::WORDS));
      bm_waddr  = phfa_pkg::WA_W'(clr_r);
      bm_wdata  = '0;
      rec_we    = (clr_r < phfa_pkg::CLR_W'(phfa_pkg::RECORD_SLOTS));
      rec_waddr = phfa_pkg::SLOT_W'(clr_r);
      rec_wdata = '0;
    end else if (state_r == S_MWR) begin
      bm_we = 1'b1;
    end else if (state_r == S_RECWR) begin
      rec_we = 1'b1;
    end
  end

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLR: begin
        if (clr_r == phfa_pkg::CLR_W'(phfa_pkg::CLR_N - 1)) state_nxt = S_IDLE;
      end
      S_IDLE: begin
        if (in_req.valid) begin
          if (in_req.kind == phfa_pkg::KIND_FREE) state_nxt = S_SRD;
          else if (in_req.req_size == '0) state_nxt = S_DONE;
          else state_nxt = S_DIV;
        end
      end
      S_DIV: begin
        if (need_q > phfa_pkg::DIV_W'(phfa_pkg::HEAP_PAGES)) state_nxt = S_DONE;
        else state_nxt = S_LOAD;
      end
      S_LOAD: state_nxt = S_SCAN;
      S_SCAN: begin
        if (scan_end) begin
          state_nxt = found_nxt ? S_SRD : S_DONE;
        end else if (b_r == '1 && p_r != phfa_pkg::CNT_W'(phfa_pkg::HEAP_PAGES - 1)) begin
          state_nxt = S_LOAD;
        end
      end
      S_SRD: state_nxt = S_SWT;
      S_SWT: begin
        if (kind_r == phfa_pkg::KIND_ALLOC) begin
          if (!rec_valid) state_nxt = S_MSET;
          else if (slot_last) state_nxt = S_DONE;
          else state_nxt = S_SRD;
        end else begin
          if (rec_valid) state_nxt = S_MUL;
          else if (slot_last) state_nxt = S_DONE;
          else state_nxt = S_SRD;
        end
      end
      S_MSET: state_nxt = S_MRD;
      S_MRD: state_nxt = S_MWR;
      S_MWR: state_nxt = (m_r == mlast_r) ? S_RECWR : S_MRD;
      S_RECWR: state_nxt = (kind_r == phfa_pkg::KIND_ALLOC) ? S_MUL : S_DONE;
      S_MUL: state_nxt = (kind_r == phfa_pkg::KIND_ALLOC) ? S_DONE : S_FCMP;
      S_FCMP: begin
        if (match) state_nxt = S_MSET;
        else if (slot_last) state_nxt = S_DONE;
        else state_nxt = S_SRD;
      end
      S_DONE: begin
        if (out_load) state_nxt = S_IDLE;
      end
      default: state_nxt = S_CLR;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      clr_r       <= '0;
      out_valid_r <= 1'b0;
      best_fit_r  <= 1'b0;
      heap_base_r <= '0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLR) begin
        clr_r <= clr_r + 1'b1;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_rsp.ready) begin
        out_valid_r <= 1'b0;
      end
      if (cfg_wr.valid && cfg_wr.index == phfa_pkg::CFG_BEST_FIT) begin
        best_fit_r <= cfg_wr.data[0];
      end
      if (cfg_wr.valid && cfg_wr.index == phfa_pkg::CFG_HEAP_BASE) begin
        heap_base_r <= cfg_wr.data;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= status_r;
      if (kind_r == phfa_pkg::KIND_ALLOC && status_r == phfa_pkg::ST_OK) begin
        out_addr_r <= heap_base_r + prod_r;
      end else begin
        out_addr_r <= '0;
      end
    end
    case (state_r)
      S_IDLE: begin
        kind_r    <= in_req.kind;
        faddr_r   <= in_req.free_address;
        div_d_r   <= phfa_pkg::DIV_W'(in_req.req_size) +
                     phfa_pkg::DIV_W'(phfa_pkg::PAGE_BYTES - 1);
        s_r       <= '0;
        status_r  <= phfa_pkg::ST_ZERO;
      end
      S_DIV: begin
        need_r      <= phfa_pkg::CNT_W'(need_q);
        status_r    <= phfa_pkg::ST_NO_FIT;
        p_r         <= '0;
        b_r         <= '0;
        w_r         <= '0;
        run_len_r   <= '0;
        found_r     <= 1'b0;
      end
      S_SCAN: begin
        run_len_r    <= run_len_nxt;
        run_start_r  <= run_start_nxt;
        found_r      <= found_nxt;
        best_start_r <= best_start_nxt;
        best_len_r   <= best_len_nxt;
        p_r          <= p_r + 1'b1;
        b_r          <= b_r + 1'b1;
        if (b_r == '1) begin
          w_r <= w_r + 1'b1;
        end
        s_r <= '0;
      end
      S_SWT: begin
        if (kind_r == phfa_pkg::KIND_ALLOC) begin
          lo_r     <= best_start_r;
          cnt_r    <= need_r;
          status_r <= phfa_pkg::ST_FULL;
          if (rec_valid && !slot_last) s_r <= s_r + 1'b1;
        end else begin
          lo_r     <= rec_start;
          cnt_r    <= rec_count;
          status_r <= phfa_pkg::ST_NOT_FOUND;
          if (!rec_valid && !slot_last) s_r <= s_r + 1'b1;
        end
      end
      S_MSET: begin
        m_r      <= word_of(phfa_pkg::CNT_W'(lo_r));
        mlast_r  <= word_of(hi - 1'b1);
        status_r <= phfa_pkg::ST_OK;
      end
      S_MWR: begin
        m_r <= m_r + 1'b1;
      end
      S_MUL: begin
        prod_r <= 32'(lo_r) * 32'(phfa_pkg::PAGE_BYTES);
      end
      S_FCMP: begin
        if (!match && !slot_last) s_r <= s_r + 1'b1;
      end
      default: begin
      end
    endcase
  end

`ifndef NO_ASSERTIONS
  a_need_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN) |->
      (need_r != '0 && need_r <= phfa_pkg::CNT_W'(phfa_pkg::HEAP_PAGES)))
    else $error("page count out of range during bitmap scan");

  a_mark_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_MWR) |-> (m_r <= mlast_r))
    else $error("marking ran past the last bitmap word");

  a_idle_no_write: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> (!bm_we && !rec_we))
    else $error("RAM written while idle");

  a_rsp_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r == S_DONE))
    else $error("response raised outside the completion state");
`endif

endmodule
